/* rtl/core/vna_pkg.sv */
// ----------------------------------------------------------------------------
// vna_pkg
// shared types and constants for the vertex normal accumulator
// ----------------------------------------------------------------------------
package vna_pkg;

    localparam int unsigned CoordW = 24;
    localparam int unsigned SumW   = 48;
    localparam int unsigned IdxW   = 16;
    localparam int unsigned CntW   = 13;

    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_TRI  = 2'd1,
        KIND_READ = 2'd2,
        KIND_BAD  = 2'd3
    } t_kind;

    // classified command handed from front to back
    typedef struct packed {
        logic                     err;
        t_kind                    kind;
        logic [IdxW-1:0]          idx_a;
        logic [IdxW-1:0]          idx_b;
        logic [IdxW-1:0]          idx_c;
        logic signed [CoordW-1:0] px;
        logic signed [CoordW-1:0] py;
        logic signed [CoordW-1:0] pz;
    } t_cmd;

    typedef struct packed {
        logic                   status;
        logic signed [SumW-1:0] sx;
        logic signed [SumW-1:0] sy;
        logic signed [SumW-1:0] sz;
    } t_res;

    // saturating 48-bit add
    function automatic logic signed [SumW-1:0] sat_add(
        input logic signed [SumW-1:0] a,
        input logic signed [SumW-1:0] b
    );
        logic signed [SumW:0] s;
        s = {a[SumW-1], a} + {b[SumW-1], b};
        if (s[SumW] != s[SumW-1]) begin
            sat_add = s[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
        end else begin
            sat_add = s[SumW-1:0];
        end
    endfunction

endpackage

/* rtl/core/vna_ram.sv */
// ----------------------------------------------------------------------------
// vna_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module vna_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write one entry when enabled; always read the addressed entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

/* rtl/core/vna_front.sv */
// ----------------------------------------------------------------------------
// vna_front
// range checks incoming items and queues them for the back end
// ----------------------------------------------------------------------------
module vna_front #(
    parameter int unsigned MAX_VERTICES = 4096,
    parameter int unsigned QDEPTH       = 2
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [vna_pkg::CntW-1:0] i_vertex_count,
    input  logic                     i_push,
    output logic                     o_full,
    input  vna_pkg::t_cmd            i_cmd,
    output logic                     o_cmd_valid,
    output vna_pkg::t_cmd            o_cmd,
    input  logic                     i_cmd_take
);
    import vna_pkg::*;

    localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam logic [16:0] MaxV = 17'(MAX_VERTICES);

    logic [16:0]   lim;
    logic          bad_a, bad_b, bad_c;
    t_cmd          cls;
    t_cmd          r_q [QDEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;
    logic          wr, rd;

    // effective index limit
    assign lim   = ({4'd0, i_vertex_count} < MaxV) ? {4'd0, i_vertex_count} : MaxV;
    assign bad_a = {1'b0, i_cmd.idx_a} >= lim;
    assign bad_b = {1'b0, i_cmd.idx_b} >= lim;
    assign bad_c = {1'b0, i_cmd.idx_c} >= lim;

    // classify
    always_comb begin
        cls = i_cmd;
        case (i_cmd.kind)
            KIND_LOAD, KIND_READ: cls.err = bad_a;
            KIND_TRI:             cls.err = bad_a | bad_b | bad_c;
            default:              cls.err = 1'b1;
        endcase
    end

    assign o_full      = (r_cnt == (PW+1)'(QDEPTH));
    assign wr          = i_push & ~o_full;
    assign o_cmd_valid = (r_cnt != '0);
    assign rd          = i_cmd_take & o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    // command queue storage
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= cls;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= (r_wp == PW'(QDEPTH-1)) ? '0 : r_wp + 1'b1;
            if (rd) r_rp <= (r_rp == PW'(QDEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(wr) - (PW+1)'(rd);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PW+1)'(QDEPTH)) else $error("queue overflow");
    a_full_noinc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full && !rd |=> o_full) else $error("full dropped without pop");
    a_empty_stay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_cmd_valid && !wr |=> !o_cmd_valid) else $error("phantom command");
endmodule

/* rtl/core/vna_back.sv */
// ----------------------------------------------------------------------------
// vna_back
// sequencer doing loads, reads and triangle accumulation on the stores
// ----------------------------------------------------------------------------
module vna_back #(
    parameter int unsigned MAX_VERTICES = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  vna_pkg::t_cmd i_cmd,
    output logic          o_cmd_take,
    output logic          o_empty,
    input  logic          i_pop,
    output vna_pkg::t_res o_res
);
    import vna_pkg::*;

    localparam int unsigned AW = $clog2(MAX_VERTICES);
    localparam int unsigned EW = CoordW + 1;
    localparam int unsigned PW = 2 * EW;
    localparam int unsigned CW = PW + 1;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_RDA  = 9'b000000010,
        S_RDB  = 9'b000000100,
        S_RDC  = 9'b000001000,
        S_MUL  = 9'b000010000,
        S_CRS  = 9'b000100000,
        S_UPD  = 9'b001000000,
        S_WR   = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    t_state r_st, n_st;
    t_cmd   r_cmd;
    logic [1:0] r_k;
    logic signed [CoordW-1:0] r_ax, r_ay, r_az;
    logic signed [EW-1:0] r_e0x, r_e0y, r_e0z, r_e1x, r_e1y, r_e1z;
    logic signed [PW-1:0] r_p [6];
    logic signed [SumW-1:0] r_nx, r_ny, r_nz;
    t_res   r_res;
    logic   r_full;

    logic              pos_we, sum_we;
    logic [AW-1:0]     addr;
    logic [3*CoordW-1:0] pos_wd, pos_rd;
    logic [3*SumW-1:0] sum_wd, sum_rd;
    logic signed [CoordW-1:0] rx, ry, rz;
    logic signed [SumW-1:0]   sx, sy, sz;
    logic signed [CW-1:0] cx, cy, cz;

    vna_ram #(.WIDTH(3*CoordW), .DEPTH(MAX_VERTICES)) u_pos (
        .i_clk(i_clk), .i_we(pos_we), .i_addr(addr), .i_wdata(pos_wd), .o_rdata(pos_rd));
    vna_ram #(.WIDTH(3*SumW), .DEPTH(MAX_VERTICES)) u_sum (
        .i_clk(i_clk), .i_we(sum_we), .i_addr(addr), .i_wdata(sum_wd), .o_rdata(sum_rd));

    assign {rx, ry, rz} = pos_rd;
    assign {sx, sy, sz} = sum_rd;

    // corner address select
    always_comb begin
        case (r_k)
            2'd1:    addr = r_cmd.idx_b[AW-1:0];
            2'd2:    addr = r_cmd.idx_c[AW-1:0];
            default: addr = r_cmd.idx_a[AW-1:0];
        endcase
    end

    assign pos_we = (r_st == S_RDA) && (r_cmd.kind == KIND_LOAD) && !r_cmd.err;
    assign pos_wd = {r_cmd.px, r_cmd.py, r_cmd.pz};
    assign sum_we = ((r_st == S_RDA) && (r_cmd.kind == KIND_LOAD) && !r_cmd.err)
                  || (r_st == S_WR);
    assign sum_wd = (r_st == S_WR) ? {sat_add(sx, r_nx), sat_add(sy, r_ny), sat_add(sz, r_nz)}
                                   : '0;

    // cross differences, floor shift is an arithmetic shift
    assign cx = CW'(r_p[0]) - CW'(r_p[1]);
    assign cy = CW'(r_p[2]) - CW'(r_p[3]);
    assign cz = CW'(r_p[4]) - CW'(r_p[5]);

    assign o_cmd_take = (r_st == S_IDLE) && i_cmd_valid;
    assign o_empty    = !r_full;
    assign o_res      = r_res;

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: if (i_cmd_valid) n_st = S_RDA;
            S_RDA: begin
                if (r_cmd.err || r_cmd.kind != KIND_TRI) n_st = S_OUT;
                else n_st = S_RDB;
            end
            S_RDB: n_st = S_RDC;
            S_RDC: n_st = S_MUL;
            S_MUL: n_st = S_CRS;
            S_CRS: n_st = S_UPD;
            S_UPD: n_st = S_WR;
            S_WR:  n_st = (r_k == 2'd2) ? S_OUT : S_UPD;
            S_OUT: if (!r_full || i_pop) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_full <= 1'b0;
            r_k    <= 2'd0;
        end else begin
            r_st <= n_st;
            if (r_st == S_OUT && (!r_full || i_pop)) r_full <= 1'b1;
            else if (i_pop && r_full) r_full <= 1'b0;
            case (r_st)
                S_IDLE:  r_k <= 2'd0;
                // non-triangle items keep the first index on the rams while they wait
                S_RDA:   r_k <= (r_cmd.kind == KIND_TRI && !r_cmd.err) ? 2'd1 : 2'd0;
                S_RDB:   r_k <= 2'd2;
                S_CRS:   r_k <= 2'd0;
                S_WR:    r_k <= r_k + 2'd1;
                default: r_k <= r_k;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_st)
            S_IDLE: r_cmd <= i_cmd;
            S_RDB: begin
                r_ax <= rx; r_ay <= ry; r_az <= rz;
            end
            S_RDC: begin
                r_e0x <= EW'(rx) - EW'(r_ax);
                r_e0y <= EW'(ry) - EW'(r_ay);
                r_e0z <= EW'(rz) - EW'(r_az);
            end
            S_MUL: begin
                r_e1x <= EW'(rx) - EW'(r_ax);
                r_e1y <= EW'(ry) - EW'(r_ay);
                r_e1z <= EW'(rz) - EW'(r_az);
            end
            S_CRS: begin
                r_p[0] <= r_e0y * r_e1z; r_p[1] <= r_e0z * r_e1y;
                r_p[2] <= r_e0z * r_e1x; r_p[3] <= r_e0x * r_e1z;
                r_p[4] <= r_e0x * r_e1y; r_p[5] <= r_e0y * r_e1x;
            end
            S_UPD: begin
                r_nx <= SumW'(cx >>> 12);
                r_ny <= SumW'(cy >>> 12);
                r_nz <= SumW'(cz >>> 12);
            end
            S_OUT: begin
                if (!r_full || i_pop) begin
                    r_res.status <= r_cmd.err;
                    if (!r_cmd.err && r_cmd.kind == KIND_READ) begin
                        r_res.sx <= sx; r_res.sy <= sy; r_res.sz <= sz;
                    end else begin
                        r_res.sx <= '0; r_res.sy <= '0; r_res.sz <= '0;
                    end
                end
            end
            default: ;
        endcase
    end

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_st)) else $error("state not one-hot");
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_take |=> r_st == S_RDA) else $error("take outside idle");
    a_err_nowrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmd.err && r_st != S_IDLE |-> !sum_we && !pos_we) else $error("write on error");
endmodule

/* rtl/core/vertex_normal_accumulate.sv */
// ----------------------------------------------------------------------------
// vertex_normal_accumulate
// area weighted vertex normal accumulation over position and sum stores
// ----------------------------------------------------------------------------
// steps: a load, read or rejected item passes RDA and OUT; a triangle passes RDA,
//   RDB, RDC, MUL, CRS, UPD and WR per corner, then OUT, which waits while a result is unpopped
// throughput: one item at a time in the back end sequencer (single-port rams)
// a two entry command queue lets new items be taken while one is at work
// reset: synchronous active low, clears control and sets vertex_count to 4096;
//   stores are undefined until loaded, no clearing pass
module vertex_normal_accumulate #(
    parameter int unsigned MAX_VERTICES = 4096
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [12:0]  i_cfg_wdata,
    input  logic         push,
    output logic         full,
    input  logic [1:0]   i_kind,
    input  logic [15:0]  i_vertex_index,
    input  logic signed [23:0] i_pos_x,
    input  logic signed [23:0] i_pos_y,
    input  logic signed [23:0] i_pos_z,
    input  logic [15:0]  i_corner_a,
    input  logic [15:0]  i_corner_b,
    input  logic [15:0]  i_corner_c,
    output logic         empty,
    input  logic         pop,
    output logic         o_status,
    output logic signed [47:0] o_sum_x,
    output logic signed [47:0] o_sum_y,
    output logic signed [47:0] o_sum_z
);
    import vna_pkg::*;

    logic [CntW-1:0] r_vertex_count;
    t_cmd cmd_in, q_cmd;
    logic q_valid, q_take;
    t_res res;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vertex_count <= CntW'(4096);
        else if (i_cfg_we) r_vertex_count <= i_cfg_wdata;
    end

    // pack the incoming transaction
    always_comb begin
        cmd_in.err  = 1'b0;
        cmd_in.kind = t_kind'(i_kind);
        cmd_in.idx_a = (i_kind == KIND_TRI) ? i_corner_a : i_vertex_index;
        cmd_in.idx_b = i_corner_b;
        cmd_in.idx_c = i_corner_c;
        cmd_in.px = i_pos_x;
        cmd_in.py = i_pos_y;
        cmd_in.pz = i_pos_z;
    end

    vna_front #(.MAX_VERTICES(MAX_VERTICES), .QDEPTH(2)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vertex_count(r_vertex_count),
        .i_push(push), .o_full(full), .i_cmd(cmd_in),
        .o_cmd_valid(q_valid), .o_cmd(q_cmd), .i_cmd_take(q_take));

    vna_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(q_valid), .i_cmd(q_cmd),
        .o_cmd_take(q_take), .o_empty(empty), .i_pop(pop), .o_res(res));

    assign o_status = res.status;
    assign o_sum_x  = res.sx;
    assign o_sum_y  = res.sy;
    assign o_sum_z  = res.sz;
endmodule
